/* rtl/ihex_pkg.sv */
// Shared types, constants and helpers for the Intel HEX record encoder.
`timescale 1ns / 1ps

package ihex_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd1;

  localparam logic [15:0] RESET_BASE   = 16'h3400;
  localparam logic [7:0]  RESET_LENGTH = 8'd32;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] RECORD_TYPE_DATA = 8'h00;

  // Character positions within one full byte request (header, data, trailer)
  typedef logic [3:0] pos_t;
  localparam pos_t POS_COLON    = 4'd0;
  localparam pos_t POS_CNT_HI   = 4'd1;
  localparam pos_t POS_CNT_LO   = 4'd2;
  localparam pos_t POS_AHI_HI   = 4'd3;
  localparam pos_t POS_AHI_LO   = 4'd4;
  localparam pos_t POS_ALO_HI   = 4'd5;
  localparam pos_t POS_ALO_LO   = 4'd6;
  localparam pos_t POS_TYPE_HI  = 4'd7;
  localparam pos_t POS_TYPE_LO  = 4'd8;
  localparam pos_t POS_DATA_HI  = 4'd9;
  localparam pos_t POS_DATA_LO  = 4'd10;
  localparam pos_t POS_CSUM_HI  = 4'd11;
  localparam pos_t POS_CSUM_LO  = 4'd12;
  localparam pos_t POS_NEWLINE  = 4'd13;

  // Everything the serializer needs to print one input byte
  typedef struct packed {
    logic        has_header;
    logic        has_trailer;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  csum;
  } frame_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

/* rtl/intel_hex_record_encoder.sv */
// Top level of the Intel HEX record encoder: byte stream in, HEX text out.
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  ------------------------------
//  in       input      in_valid/in_stall  data_byte[7:0]
//  out      output     out_valid/out_stall text_char[7:0], last_of_run
//  cfg      input      cfg_valid/cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// One character leaves per cycle while out_stall is low, so a byte request
// prints 2 characters inside a record, 11 when it opens one, 5 when it closes
// one and 14 when it does both. An accepted request passes the pend, cur and
// output registers before its first character appears. Reset (rst, synchronous)
// restores base_address 0x3400, record_length 32 and closes any open record.
// A byte is taken while the previous one is still being printed; a stall on
// the output holds the current character and backs up into in_stall.
`timescale 1ns / 1ps

module intel_hex_record_encoder (
  input  logic                           clk,
  input  logic                           rst,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  // character output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     text_char,
  output logic                           last_of_run,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic [15:0] base_address;
  logic [7:0]  record_length;

  ihex_pkg::frame_t pend;
  logic             pend_valid;
  logic             pop;

  // registers are always writable; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= ihex_pkg::RESET_BASE;
      record_length <= ihex_pkg::RESET_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ihex_pkg::CFG_BASE_ADDRESS:  base_address  <= cfg_data;
        ihex_pkg::CFG_RECORD_LENGTH: record_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // record state, checksum and address; holds one request ahead
  ihex_frame_build u_build (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .base_address  (base_address),
    .record_length (record_length),
    .pop           (pop),
    .pend          (pend),
    .pend_valid    (pend_valid)
  );

  // prints header, data digits and trailer one character per cycle unless out_stall holds it
  ihex_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .pend        (pend),
    .pend_valid  (pend_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_char   (text_char),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/ihex_frame_build.sv */
// Record bookkeeping and the one-deep request register feeding the serializer.
`timescale 1ns / 1ps

module ihex_frame_build (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         base_address,
  input  logic [7:0]          record_length,
  input  logic                pop,
  output ihex_pkg::frame_t    pend,
  output logic                pend_valid
);

  logic [7:0]  byte_in_record;
  logic [15:0] address_offset;
  logic [7:0]  running_checksum;

  logic             accept;
  logic [15:0]      addr;
  logic [7:0]       sum_start;
  logic [7:0]       sum_all;
  logic [8:0]       filled;
  logic [8:0]       limit;
  logic             closes;
  ihex_pkg::frame_t frame_next;

  assign in_stall = pend_valid && !pop;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    addr      = base_address + address_offset;
    sum_start = (byte_in_record == 8'd0)
              ? (record_length + addr[15:8] + addr[7:0] + ihex_pkg::RECORD_TYPE_DATA)
              : running_checksum;
    sum_all   = sum_start + data_byte;
    filled    = {1'b0, byte_in_record} + 9'd1;
    // zero length means a 256-byte record
    limit     = (record_length == 8'd0) ? 9'd256 : {1'b0, record_length};
    closes    = filled >= limit;

    frame_next.has_header  = byte_in_record == 8'd0;
    frame_next.has_trailer = closes;
    frame_next.count       = record_length;
    frame_next.addr        = addr;
    frame_next.data        = data_byte;
    frame_next.csum        = 8'd0 - sum_all;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_record   <= 8'd0;
      address_offset   <= 16'd0;
      running_checksum <= 8'd0;
      pend_valid       <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid       <= 1'b1;
        address_offset   <= address_offset + 16'd1;
        byte_in_record   <= closes ? 8'd0 : filled[7:0];
        running_checksum <= closes ? 8'd0 : sum_all;
      end else if (pop) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= frame_next;
    end
  end

endmodule

/* rtl/ihex_serializer.sv */
// Walks one request's character positions and drives the registered output.
`timescale 1ns / 1ps

module ihex_serializer (
  input  logic             clk,
  input  logic             rst,
  input  ihex_pkg::frame_t pend,
  input  logic             pend_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       text_char,
  output logic             last_of_run
);

  ihex_pkg::frame_t cur;
  logic             cur_valid;
  ihex_pkg::pos_t   idx;

  logic           load_out;
  logic           adv;
  logic           is_end;
  ihex_pkg::pos_t end_pos;
  ihex_pkg::pos_t start_pos;
  logic [7:0]     char_next;

  always_comb begin
    end_pos   = cur.has_trailer ? ihex_pkg::POS_NEWLINE : ihex_pkg::POS_DATA_LO;
    start_pos = pend.has_header ? ihex_pkg::POS_COLON : ihex_pkg::POS_DATA_HI;
    load_out  = !out_valid || !out_stall;
    adv       = cur_valid && load_out;
    is_end    = idx == end_pos;
    pop       = pend_valid && (!cur_valid || (adv && is_end));
  end

  always_comb begin
    unique case (idx)
      ihex_pkg::POS_COLON:   char_next = ihex_pkg::CHAR_COLON;
      ihex_pkg::POS_CNT_HI:  char_next = ihex_pkg::hex_char(cur.count[7:4]);
      ihex_pkg::POS_CNT_LO:  char_next = ihex_pkg::hex_char(cur.count[3:0]);
      ihex_pkg::POS_AHI_HI:  char_next = ihex_pkg::hex_char(cur.addr[15:12]);
      ihex_pkg::POS_AHI_LO:  char_next = ihex_pkg::hex_char(cur.addr[11:8]);
      ihex_pkg::POS_ALO_HI:  char_next = ihex_pkg::hex_char(cur.addr[7:4]);
      ihex_pkg::POS_ALO_LO:  char_next = ihex_pkg::hex_char(cur.addr[3:0]);
      ihex_pkg::POS_TYPE_HI: char_next = ihex_pkg::hex_char(ihex_pkg::RECORD_TYPE_DATA[7:4]);
      ihex_pkg::POS_TYPE_LO: char_next = ihex_pkg::hex_char(ihex_pkg::RECORD_TYPE_DATA[3:0]);
      ihex_pkg::POS_DATA_HI: char_next = ihex_pkg::hex_char(cur.data[7:4]);
      ihex_pkg::POS_DATA_LO: char_next = ihex_pkg::hex_char(cur.data[3:0]);
      ihex_pkg::POS_CSUM_HI: char_next = ihex_pkg::hex_char(cur.csum[7:4]);
      ihex_pkg::POS_CSUM_LO: char_next = ihex_pkg::hex_char(cur.csum[3:0]);
      ihex_pkg::POS_NEWLINE: char_next = ihex_pkg::CHAR_NEWLINE;
      default:               char_next = ihex_pkg::CHAR_NEWLINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= cur_valid;
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (adv && is_end) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      text_char   <= char_next;
      last_of_run <= is_end;
    end
    if (pop) begin
      cur <= pend;
      idx <= start_pos;
    end else if (adv) begin
      idx <= idx + 4'd1;
    end
  end

endmodule

/* rtl/ihex_checker.sv */
// Port-level checks for the Intel HEX record encoder, bound to the top level.
`timescale 1ns / 1ps

module ihex_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] text_char,
  input logic       last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(last_of_run))
    else $error("output changed while stalled");

  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == ihex_pkg::CHAR_NEWLINE |-> last_of_run)
    else $error("newline not marked as last character");

  a_colon_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == ihex_pkg::CHAR_COLON |-> !last_of_run)
    else $error("colon marked as last character");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .text_char   (text_char),
  .last_of_run (last_of_run)
);

/* sim/tb.sv */
// Self-checking bench for the Intel HEX record encoder: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 6;     // settle after the owed text drains
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off in the last phase
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS    = 105;   // three phases of at least 105 requests each

  // Indexes past the register file; writes there must be dropped
  localparam logic [ihex_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [ihex_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [7:0]                     data_byte = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     text_char;
  logic                           last_of_run;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data  = 16'h0000;

  intel_hex_record_encoder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_char   (text_char),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder model: register copies, record state, expected text
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic [15:0] model_base    = ihex_pkg::RESET_BASE;
  logic [7:0]  model_length  = ihex_pkg::RESET_LENGTH;
  logic [7:0]  fill_count    = 8'd0;   // data bytes in the open record, 0 = none open
  logic [15:0] bytes_encoded = 16'd0;  // running load offset, wraps at 64K
  logic [7:0]  record_sum    = 8'd0;   // header + data bytes of the open record

  text_char_t  pending_text[$];        // characters still owed by the block
  logic [7:0]  echoed_text[$];         // raw capture used by the directed rows

  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;

  function automatic logic [7:0] digit_ascii(input logic [3:0] nib);
    // '0'..'9' then 'A'..'F'
    return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h41 + {4'd0, nib} - 8'd10);
  endfunction

  function automatic void push_char(input logic [7:0] c);
    pending_text.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void push_hex(input logic [7:0] b);
    push_char(digit_ascii(b[7:4]));
    push_char(digit_ascii(b[3:0]));
    record_sum = record_sum + b;
  endfunction

  function automatic void apply_register(input logic [ihex_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [15:0] value);
    case (idx)
      ihex_pkg::CFG_BASE_ADDRESS:  model_base = value;
      ihex_pkg::CFG_RECORD_LENGTH: model_length = value[7:0];
      default: ;  // spare indexes are dropped
    endcase
  endfunction

  // One accepted byte: optional header, two data digits, optional trailer
  function automatic void encode_byte(input logic [7:0] b);
    logic [15:0] rec_addr;
    logic [8:0]  span;
    logic [8:0]  filled;
    logic [7:0]  csum;
    text_char_t  tail;
    if (fill_count == 8'd0) begin
      rec_addr   = model_base + bytes_encoded;
      record_sum = 8'd0;
      push_char(ihex_pkg::CHAR_COLON);
      push_hex(model_length);
      push_hex(rec_addr[15:8]);
      push_hex(rec_addr[7:0]);
      push_hex(ihex_pkg::RECORD_TYPE_DATA);
    end
    push_hex(b);
    bytes_encoded = bytes_encoded + 16'd1;
    // length 0 means a 256-byte record; a shrunk length closes on this byte
    span   = (model_length == 8'd0) ? 9'd256 : {1'b0, model_length};
    filled = {1'b0, fill_count} + 9'd1;
    if (filled >= span) begin
      csum = 8'd0 - record_sum;
      push_hex(csum);
      push_char(ihex_pkg::CHAR_NEWLINE);
      fill_count = 8'd0;
      record_sum = 8'd0;
    end else begin
      fill_count = filled[7:0];
    end
    tail = pending_text.pop_back();
    tail.last = 1'b1;
    pending_text.push_back(tail);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: all three handshakes sampled on the same edge, pre-edge values
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte);
      end
      if (out_valid && !out_stall) begin
        echoed_text.push_back(text_char);
        if (pending_text.size() == 0) begin
          flag_mismatch($sformatf("unexpected char 8'h%02h", text_char));
        end else begin
          want = pending_text.pop_front();
          if (text_char !== want.ch) begin
            flag_mismatch($sformatf("text_char 8'h%02h, want 8'h%02h", text_char, want.ch));
          end
          if (last_of_run !== want.last) begin
            flag_mismatch($sformatf("last_of_run %b, want %b (char 8'h%02h)",
                                    last_of_run, want.last, want.ch));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold when the stimulus asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if nothing moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first; valid stays up after accept
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let every owed character drain, then a short settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_text.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [ihex_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: a byte request (value[7:0]) or a register write.
  // golden holds the full text of a byte request where it is obvious; empty
  // rows rely on the model alone.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_BYTE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [ihex_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                    value;
    string                          golden;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 26;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // reset values: base 0x3400, 32-byte records
    '{ROW_BYTE,  '0,                          16'h0000, ":2034000000"},
    '{ROW_BYTE,  '0,                          16'h00FF, "FF"},
    '{ROW_BYTE,  '0,                          16'h00A5, "A5"},
    // shrink below current fill: next byte closes the record
    '{ROW_WRITE, ihex_pkg::CFG_RECORD_LENGTH, 16'h0001, ""},
    '{ROW_BYTE,  '0,                          16'h005A, "5AAE\n"},
    // one-byte records: header, data, checksum, newline
    '{ROW_BYTE,  '0,                          16'h0000, ":0134040000C7\n"},
    // base + offset wraps past 0xFFFF
    '{ROW_WRITE, ihex_pkg::CFG_BASE_ADDRESS,  16'hFFFF, ""},
    '{ROW_BYTE,  '0,                          16'h00FF, ":01000400FFFC\n"},
    // length 0 = 256-byte records, count field 00; upper data bits ignored
    '{ROW_WRITE, ihex_pkg::CFG_RECORD_LENGTH, 16'hFF00, ""},
    '{ROW_WRITE, ihex_pkg::CFG_BASE_ADDRESS,  16'h0000, ""},
    '{ROW_BYTE,  '0,                          16'h0012, ":0000060012"},
    // writes to spare indexes change nothing
    '{ROW_WRITE, CFG_SPARE_2,                 16'h1234, ""},
    '{ROW_WRITE, CFG_SPARE_3,                 16'hFFFF, ""},
    '{ROW_BYTE,  '0,                          16'h0080, "80"},
    // grow the length mid-record, then cut it under the fill
    '{ROW_WRITE, ihex_pkg::CFG_RECORD_LENGTH, 16'h00FF, ""},
    '{ROW_BYTE,  '0,                          16'h0001, "01"},
    '{ROW_WRITE, ihex_pkg::CFG_RECORD_LENGTH, 16'h0002, ""},
    '{ROW_BYTE,  '0,                          16'h007F, ""},
    '{ROW_WRITE, ihex_pkg::CFG_RECORD_LENGTH, 16'h0003, ""},
    '{ROW_BYTE,  '0,                          16'h000F, ""},
    '{ROW_BYTE,  '0,                          16'h00F0, ""},
    // base change lands at the next header only
    '{ROW_WRITE, ihex_pkg::CFG_BASE_ADDRESS,  16'hFFFE, ""},
    '{ROW_BYTE,  '0,                          16'h0055, ""},
    '{ROW_BYTE,  '0,                          16'h00AA, ""},
    '{ROW_BYTE,  '0,                          16'h0033, ""},
    '{ROW_BYTE,  '0,                          16'h00CC, ""}
  };

  // Idle plan per random phase
  int send_plan [3] = '{38, 78, 0};
  int recv_plan [3] = '{78, 38, 0};

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t  row;
    int         phase_sent;
    int         burst;
    int         pick;
    logic [7:0] b;
    logic [7:0] len;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = send_plan[0];
    recv_idle_pct = recv_plan[0];

    // ---- directed ----
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        write_register(row.idx, row.value);
      end else if (row.golden.len() == 0) begin
        send_byte(row.value[7:0]);
      end else begin
        // isolate this request's text, then compare it verbatim
        wait_idle();
        echoed_text.delete();
        send_byte(row.value[7:0]);
        wait_idle();
        if (echoed_text.size() != row.golden.len()) begin
          flag_mismatch($sformatf("row %0d: %0d chars, want %0d",
                                  r, echoed_text.size(), row.golden.len()));
        end else begin
          for (int i = 0; i < row.golden.len(); i++) begin
            if (echoed_text[i] !== row.golden[i]) begin
              flag_mismatch($sformatf("row %0d char %0d: 8'h%02h, want 8'h%02h",
                                      r, i, echoed_text[i], row.golden[i]));
            end
          end
        end
      end
    end

    // ---- random: three idle phases ----
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_plan[phase];
      recv_idle_pct = recv_plan[phase];
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        // maybe retune between bursts; registers only move while idle
        pick = $urandom_range(9);
        if (pick <= 7) begin
          wait_idle();
          case (pick)
            0, 1, 2, 3: begin
              len = 8'($urandom_range(1, 8));
              write_register(ihex_pkg::CFG_RECORD_LENGTH, {8'($urandom), len});
            end
            4: begin
              case ($urandom_range(2))
                0:       len = 8'd0;
                1:       len = 8'd1;
                default: len = 8'd255;
              endcase
              write_register(ihex_pkg::CFG_RECORD_LENGTH, {8'($urandom), len});
            end
            5: write_register(ihex_pkg::CFG_BASE_ADDRESS, 16'($urandom));
            6: write_register(ihex_pkg::CFG_BASE_ADDRESS,
                              $urandom_range(1) ? 16'hFFFF : 16'h0000);
            default: write_register($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                                    16'($urandom));
          endcase
        end
        // last phase: the sender runs flat out into a long output hold
        if (phase == 2 && phase_sent == 0) begin
          holds_asked++;
        end
        burst = $urandom_range(8, 30);
        for (int k = 0; k < burst; k++) begin
          // lean on the all-zero and all-one bytes now and then
          b = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
          send_byte(b);
        end
        phase_sent += burst;
      end
    end

    // ---- wind down ----
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
